>>> rtl/ccp_pkg.sv
// Shared constants and the arctangent table for the CORDIC polar converter.
`timescale 1ns / 1ps
package ccp_pkg;

  localparam int ITERATIONS_DEF = 16;
  localparam int ATAN_ENTRIES   = 24;
  localparam int COORD_W        = 16;
  localparam int FRAC_GUARD     = 14;
  localparam int DATA_W         = 32;   // 2 extra integer bits over COORD_W + FRAC_GUARD
  localparam int ANG_W          = 17;   // accumulator, one bit of headroom over Q3.13
  localparam int MAG_W          = 16;
  localparam int GAIN_W         = 16;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = ANG_W'(12868);
  localparam logic [GAIN_W-1:0]       GAIN_Q16    = GAIN_W'(39797);

  // Largest angle magnitude the accumulator can reach: pi/2 plus the whole table.
  localparam int ANG_LIMIT = 12868 + 14280;

  // atan(2^-i) in Q3.13, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q13(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:       v = ANG_W'(6434);
      1:       v = ANG_W'(3798);
      2:       v = ANG_W'(2007);
      3:       v = ANG_W'(1019);
      4:       v = ANG_W'(511);
      5:       v = ANG_W'(256);
      6:       v = ANG_W'(128);
      7:       v = ANG_W'(64);
      8:       v = ANG_W'(32);
      9:       v = ANG_W'(16);
      10:      v = ANG_W'(8);
      11:      v = ANG_W'(4);
      12:      v = ANG_W'(2);
      13:      v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ccp_if.sv
// Valid/ready stream interfaces for the Cartesian input and polar output items.
`timescale 1ns / 1ps
interface ccp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface ccp_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] magnitude;
  logic signed [15:0] angle_rad;

  modport source (output valid, output magnitude, output angle_rad, input ready);
  modport sink   (input valid, input magnitude, input angle_rad, output ready);
endinterface

>>> rtl/cordic_cartesian_to_polar.sv
// Pipelined CORDIC vectoring unit: Cartesian (x, y) to magnitude and angle.
//
// Usage:
//   in_i  carries one point per item (x_coord, y_coord, signed 16-bit integers).
//   out_o carries one result per item: magnitude (unsigned, input scale,
//   rounded half up) and angle_rad (signed Q3.13 radians).
//   Results leave in the order the points came in, exactly one per point.
// Structure: a quarter-turn pre-rotation stage, ITERATIONS micro-rotation
//   stages (at most ATAN_ENTRIES; one fixed shift and one arctangent constant
//   each), a gain multiply stage and a round/saturate output stage.
// Path: an accepted point passes the pre-rotation, micro-rotation, gain multiply
//   and output registers before out_o.valid shows its result.
// Throughput: one item per cycle into every stage while the skid is empty.
// Stall: a one-entry skid register sits behind the output stage. When the
//   receiver holds ready low, the item at the output is parked there and the
//   pipeline freezes in the cycle after; in_i.ready falls only while the skid
//   entry is occupied. Nothing is dropped or duplicated.
// Reset: rst_ni is asynchronous, active low, and clears all valid bits and the
//   skid entry; payload registers are not reset. No warm-up is needed.
`timescale 1ns / 1ps
module cordic_cartesian_to_polar
  import ccp_pkg::*;
#(
  parameter int ITERATIONS = ITERATIONS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ccp_in_if.sink           in_i,
  ccp_out_if.source        out_o
);

  // steps beyond the arctangent table are not performed
  localparam int STEPS = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;
  localparam int OUT_S = STEPS + 2;
  localparam int NSTG  = STEPS + 3;
  localparam int PROD_W = DATA_W - 1 + GAIN_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RSH    = FRAC_GUARD + 16;
  localparam int MFULL_W = SUM_W - RSH;

  logic [NSTG-1:0] vld_q;
  logic            adv;      // whole pipeline advances

  // skid entry behind the output stage
  logic                    skid_vld_q;
  logic [MAG_W-1:0]        skid_mag_q;
  logic signed [15:0]      skid_ang_q;

  assign adv        = !skid_vld_q;
  assign in_i.ready = adv;

  // ---------------- valid bits ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  // ---------------- pre-rotation ----------------
  logic signed [DATA_W-1:0] x_q   [0:STEPS];
  logic signed [DATA_W-1:0] y_q   [0:STEPS];
  logic signed [ANG_W-1:0]  ang_q [0:STEPS];

  logic signed [DATA_W-1:0] xin_ext, yin_ext, x0_d, y0_d;
  logic signed [ANG_W-1:0]  a0_d;

  always_comb begin
    xin_ext = $signed({{(DATA_W-COORD_W){in_i.x_coord[COORD_W-1]}}, in_i.x_coord});
    yin_ext = $signed({{(DATA_W-COORD_W){in_i.y_coord[COORD_W-1]}}, in_i.y_coord});
    if (in_i.y_coord > 0) begin
      x0_d = yin_ext;
      y0_d = -xin_ext;
      a0_d = HALF_PI_Q13;
    end else begin
      x0_d = -yin_ext;
      y0_d = xin_ext;
      a0_d = -HALF_PI_Q13;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0]   <= x0_d <<< FRAC_GUARD;
      y_q[0]   <= y0_d <<< FRAC_GUARD;
      ang_q[0] <= a0_d;
    end
  end

  // ---------------- micro-rotations ----------------
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [ANG_W-1:0] ATAN_I = atan_q13(i);
    logic signed [DATA_W-1:0] xs, ys;
    logic                     y_pos;

    assign xs    = x_q[i] >>> i;   // floor shift
    assign ys    = y_q[i] >>> i;
    assign y_pos = (y_q[i] > 0);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (y_pos) begin
          x_q[i+1]   <= x_q[i] + ys;
          y_q[i+1]   <= y_q[i] - xs;
          ang_q[i+1] <= ang_q[i] + ATAN_I;
        end else begin
          x_q[i+1]   <= x_q[i] - ys;
          y_q[i+1]   <= y_q[i] + xs;
          ang_q[i+1] <= ang_q[i] - ATAN_I;
        end
      end
    end
  end

  // ---------------- gain multiply ----------------
  logic [PROD_W-1:0]       prod_q;
  logic                    pos_q;
  logic signed [ANG_W-1:0] ang_m_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q  <= PROD_W'(x_q[STEPS][DATA_W-2:0]) * PROD_W'(GAIN_Q16);
      pos_q   <= (x_q[STEPS] > 0);
      ang_m_q <= ang_q[STEPS];
    end
  end

  // ---------------- round and saturate ----------------
  logic [SUM_W-1:0]   sum;
  logic [MFULL_W-1:0] mag_full;
  logic [MAG_W-1:0]   mag_d;
  logic signed [15:0] ang_d;

  always_comb begin
    sum      = {1'b0, prod_q} + (SUM_W'(1) << (RSH - 1));
    mag_full = sum[SUM_W-1:RSH];
    if (!pos_q) begin
      mag_d = '0;
    end else if (mag_full > MFULL_W'({MAG_W{1'b1}})) begin
      mag_d = '1;
    end else begin
      mag_d = mag_full[MAG_W-1:0];
    end
    if (ang_m_q > ANG_W'(32767)) begin
      ang_d = 16'sh7FFF;
    end else if (ang_m_q < -ANG_W'(32768)) begin
      ang_d = 16'sh8000;
    end else begin
      ang_d = ang_m_q[15:0];
    end
  end

  logic [MAG_W-1:0]   mag_q;
  logic signed [15:0] ang_o_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q   <= mag_d;
      ang_o_q <= ang_d;
    end
  end

  // ---------------- output skid ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_o.ready) skid_vld_q <= 1'b0;
    end else if (vld_q[OUT_S] && !out_o.ready) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_mag_q <= mag_q;
      skid_ang_q <= ang_o_q;
    end
  end

  assign out_o.valid     = skid_vld_q || vld_q[OUT_S];
  assign out_o.magnitude = skid_vld_q ? skid_mag_q : mag_q;
  assign out_o.angle_rad = skid_vld_q ? skid_ang_q : ang_o_q;

endmodule

>>> rtl/ccp_checker.sv
// Port-level assertions for the CORDIC polar converter, bound to its top level.
`timescale 1ns / 1ps
module ccp_checker
  import ccp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [15:0]       magnitude_i,
  input logic signed [15:0] angle_rad_i
);

  // nothing comes out while reset is held
  a_quiet_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // a result offered and not taken stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item withdrawn before taken");

  // a receiver that took the last edge leaves the skid empty, so input is open
  a_ready_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |=> in_ready_i)
    else $error("input blocked although receiver was ready");

  // length of a 16-bit point is at most sqrt(2) * 32768
  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> magnitude_i <= 16'd46345)
    else $error("magnitude out of reachable range");

  a_ang_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (angle_rad_i <= 16'(ANG_LIMIT)) &&
                    (angle_rad_i >= -16'(ANG_LIMIT)))
    else $error("angle out of reachable range");

endmodule

bind cordic_cartesian_to_polar ccp_checker u_ccp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .magnitude_i (out_o.magnitude),
  .angle_rad_i (out_o.angle_rad)
);

>>> tb/ccp_polar_checker.sv
// Checker for the CORDIC polar converter: predicts each point's polar result and compares.
`timescale 1ns / 1ps
module ccp_polar_checker #(
  parameter int ITERATIONS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ccp_in_if    pts_i,
  ccp_out_if   res_i,
  output int   mismatch_cnt_o,
  output int   open_points_o,
  output int   checked_cnt_o
);

  localparam int ATAN_LEN  = 24;
  localparam int GUARD     = 14;
  localparam int HALF_PI   = 12868;   // pi/2 in Q3.13
  localparam longint GAIN  = 39797;   // 0.607253 in Q0.16

  // atan(2^-i) in Q3.13, rounded to nearest
  localparam int ATAN_TBL[ATAN_LEN] = '{
    6434, 3798, 2007, 1019, 511, 256, 128, 64,
    32, 16, 8, 4, 2, 1, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic        [15:0] magnitude;
    logic signed [15:0] angle_rad;
  } polar_exp_t;

  polar_exp_t polar_exp_q[$];

  function automatic polar_exp_t polar_of(input logic signed [15:0] x,
                                          input logic signed [15:0] y);
    logic signed [31:0] xr, yr, xs, ys;
    int                 ang;
    longint             prod;
    polar_exp_t         r;
    r.x_coord = x;
    r.y_coord = y;
    // quarter turn into the right half plane
    if (y > 0) begin
      xr  = 32'(y);
      yr  = 32'(x);
      yr  = -yr;
      ang = HALF_PI;
    end else begin
      xr  = 32'(y);
      xr  = -xr;
      yr  = 32'(x);
      ang = -HALF_PI;
    end
    xr = xr <<< GUARD;
    yr = yr <<< GUARD;
    for (int i = 0; i < ITERATIONS && i < ATAN_LEN; i++) begin
      xs = xr >>> i;
      ys = yr >>> i;
      if (yr > 0) begin
        xr  = xr + ys;
        yr  = yr - xs;
        ang = ang + ATAN_TBL[i];
      end else begin
        xr  = xr - ys;
        yr  = yr + xs;
        ang = ang - ATAN_TBL[i];
      end
    end
    if (xr <= 0) begin
      prod = 0;
    end else begin
      prod = (longint'(xr) * GAIN + (longint'(1) << (GUARD + 15))) >>> (GUARD + 16);
      if (prod > 65535) prod = 65535;
    end
    if (ang > 32767)  ang = 32767;
    if (ang < -32768) ang = -32768;
    r.magnitude = 16'(prod);
    r.angle_rad = 16'(ang);
    return r;
  endfunction

  // sampled at the edge, before the block and the driver update anything
  always @(posedge clk_i or negedge rst_ni) begin
    polar_exp_t e;
    int         errs;
    errs = 0;
    if (!rst_ni) begin
      polar_exp_q.delete();
      mismatch_cnt_o <= 0;
      checked_cnt_o  <= 0;
      open_points_o  <= 0;
    end else begin
      if (pts_i.valid && pts_i.ready)
        polar_exp_q.push_back(polar_of(pts_i.x_coord, pts_i.y_coord));
      if (res_i.valid && res_i.ready) begin
        if (polar_exp_q.size() == 0) begin
          $display("%0t: unexpected result mag=%0d ang=%0d", $time,
                   res_i.magnitude, res_i.angle_rad);
          errs++;
        end else begin
          e = polar_exp_q.pop_front();
          checked_cnt_o <= checked_cnt_o + 1;
          if (res_i.magnitude !== e.magnitude) begin
            $display("%0t: point (%0d,%0d) magnitude expected %0d actual %0d", $time,
                     e.x_coord, e.y_coord, e.magnitude, res_i.magnitude);
            errs++;
          end
          if (res_i.angle_rad !== e.angle_rad) begin
            $display("%0t: point (%0d,%0d) angle_rad expected %0d actual %0d", $time,
                     e.x_coord, e.y_coord, e.angle_rad, res_i.angle_rad);
            errs++;
          end
        end
      end
      if (errs != 0) mismatch_cnt_o <= mismatch_cnt_o + errs;
      open_points_o <= polar_exp_q.size();
    end
  end

endmodule

>>> tb/cordic_cartesian_to_polar_tb.sv
// Top of the CORDIC polar converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module cordic_cartesian_to_polar_tb;

  localparam int ITER          = 16;
  localparam int RAND_POINTS   = 500;
  localparam int HOLD_CYCLES   = 90;      // one long receiver hold-off, > pipeline depth
  localparam int DRAIN_CYCLES  = ITER + 8;
  localparam int LIMIT_CYCLES  = 200000;  // far beyond the slowest legal run
  localparam int IDLE_PCT      = 37;
  localparam int N_DIRECTED    = 22;

  // corners, axes, origin and its neighbors, diagonals, alternating bit patterns
  // packed as {x, y}
  localparam logic [31:0] DIRECTED[N_DIRECTED] = '{
    {16'h0000, 16'h0000}, {16'h0001, 16'h0000}, {16'hFFFF, 16'h0000},
    {16'h0000, 16'h0001}, {16'h0000, 16'hFFFF}, {16'h7FFF, 16'h0000},
    {16'h8000, 16'h0000}, {16'h0000, 16'h7FFF}, {16'h0000, 16'h8000},
    {16'h7FFF, 16'h7FFF}, {16'h8000, 16'h8000}, {16'h7FFF, 16'h8000},
    {16'h8000, 16'h7FFF}, {16'h8000, 16'h0001}, {16'h8000, 16'hFFFF},
    {16'h0001, 16'h0001}, {16'hFFFF, 16'hFFFF}, {16'h0064, 16'hFF9C},
    {16'h5555, 16'hAAAA}, {16'hAAAA, 16'h5555}, {16'hFFFF, 16'h0001},
    {16'h7FFF, 16'h0001}
  };

  localparam logic [15:0] EDGE_VALS[7] = '{
    16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF
  };

  logic clk_i;
  logic rst_ni;

  ccp_in_if  in_if();
  ccp_out_if out_if();

  int mismatch_cnt;
  int open_points;
  int checked_cnt;

  // calm, hold_req and hold_left are shared between the sender and receiver processes
  bit calm;          // no idling on either side while set
  bit hold_req;      // sender asks the receiver for its long hold-off
  int hold_left;     // receiver's own countdown of the hold-off
  int in_stall_cnt;  // cycles the block refused an offered item
  int sent_cnt;

  logic signed [15:0] px, py;

  cordic_cartesian_to_polar #(
    .ITERATIONS(ITER)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  ccp_polar_checker #(
    .ITERATIONS(ITER)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pts_i         (in_if),
    .res_i         (out_if),
    .mismatch_cnt_o(mismatch_cnt),
    .open_points_o (open_points),
    .checked_cnt_o (checked_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offer one point. Random idle cycles come first (none while calm or during
  // the hold-off, so the pipe really fills). valid then stays high until the
  // handshake; ready is sampled mid-cycle, where it is settled.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
    logic took;
    while (!(calm || hold_left > 0) && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.x_coord <= x;
    in_if.y_coord <= y;
    do begin
      @(negedge clk_i);
      took = in_if.ready;
      if (!took) in_stall_cnt++;
      @(posedge clk_i);
    end while (!took);
    sent_cnt++;
  endtask

  // Random point with a shape mix: full-range values (every bit toggles),
  // the origin neighborhood where the y <= 0 tie rule decides, axis points,
  // exact diagonals and the extreme codes.
  task automatic pick_point(output logic signed [15:0] x, output logic signed [15:0] y);
    int          kind;
    logic [15:0] m;
    kind = $urandom_range(0, 99);
    m    = 16'($urandom);
    if (kind < 40) begin
      x = 16'($urandom);
      y = 16'($urandom);
    end else if (kind < 55) begin
      x = 16'($urandom_range(0, 8) - 4);
      y = 16'($urandom_range(0, 8) - 4);
    end else if (kind < 70) begin
      if ($urandom_range(0, 1)) begin
        x = m;
        y = '0;
      end else begin
        x = '0;
        y = m;
      end
    end else if (kind < 85) begin
      x = m;
      y = $urandom_range(0, 1) ? m : -m;
    end else begin
      x = $urandom_range(0, 1) ? EDGE_VALS[$urandom_range(0, 6)] : 16'($urandom);
      y = EDGE_VALS[$urandom_range(0, 6)];
    end
  endtask

  // receiver: random ready, one long hold-off on request, calm stretch
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    in_if.valid   <= 1'b0;
    in_if.x_coord <= '0;
    in_if.y_coord <= '0;
    rst_ni        <= 1'b0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    in_stall_cnt  = 0;
    sent_cnt      = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed points
    for (int d = 0; d < N_DIRECTED; d++)
      send_point(DIRECTED[d][31:16], DIRECTED[d][15:0]);

    // random points; a calm stretch in the middle, then the long hold-off
    for (int n = 0; n < RAND_POINTS; n++) begin
      calm = (n >= 150 && n < 260);
      if (n == 320) hold_req = 1'b1;
      pick_point(px, py);
      send_point(px, py);
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    // the checker already counted the last point at its handshake edge
    @(posedge clk_i);
    wait (open_points == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d points (%0d directed: origin, axes, corners, diagonals)",
             sent_cnt, N_DIRECTED);
    $display("%0d results compared; input refused for %0d cycles under back-pressure",
             checked_cnt, in_stall_cnt);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * 12);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/ccp_pkg.sv
rtl/ccp_if.sv
rtl/cordic_cartesian_to_polar.sv
rtl/ccp_checker.sv
tb/ccp_polar_checker.sv
tb/cordic_cartesian_to_polar_tb.sv
